// ===== sv/mfbr_pkg.sv =====
// ----------------------------------------------------------------------------
// mfbr_pkg
// Types and constants shared by the MSB-first bit reader and its parts.
// ----------------------------------------------------------------------------
package mfbr_pkg;

  localparam int LEN_W         = 11;
  localparam int POS_W         = 14;
  localparam int MAX_PEEK_BITS = 32;
  localparam int WIN_BYTES     = (MAX_PEEK_BITS + 7) / 8 + 1;
  localparam int WIN_BITS      = WIN_BYTES * 8;

  localparam logic [POS_W-1:0] POS_MAX = 14'h3FFF;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PEEK  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [9:0]  byte_address;
    logic [7:0]  byte_value;
    logic [5:0]  peek_count;
    logic [13:0] advance_count;
  } req_t;

  typedef struct packed {
    logic [31:0] peek_value;
    logic [13:0] bits_left;
    logic        overrun;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PEEK,
    ST_WRITE
  } state_t;

endpackage

// ===== sv/mfbr_ram.sv =====
// ----------------------------------------------------------------------------
// mfbr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mfbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mfbr_window.sv =====
// ----------------------------------------------------------------------------
// mfbr_window
// Assemble the byte window at the bit position from the two bank words,
// zero bytes past the valid length, and extract the peeked bits.
// ----------------------------------------------------------------------------
module mfbr_window (
  input  logic [31:0]                   e_word,
  input  logic [31:0]                   o_word,
  input  logic [mfbr_pkg::POS_W-1:0]    pos,
  input  logic [mfbr_pkg::LEN_W-1:0]    len_eff,
  input  logic [5:0]                    peek_count,
  output logic [31:0]                   peek_value
);
  import mfbr_pkg::*;

  logic [31:0]         lo_word;
  logic [31:0]         hi_word;
  logic [7:0]          win [8];
  logic [WIN_BITS-1:0] span;
  logic [WIN_BITS-1:0] shifted;
  logic [WIN_BITS-1:0] aligned;
  logic [5:0]          cnt;
  logic [5:0]          drop;
  logic [LEN_W:0]      addr [WIN_BYTES];
  logic [2:0]          sel  [WIN_BYTES];

  // Odd word index: the first word sits in the odd bank
  assign lo_word = pos[5] ? o_word : e_word;
  assign hi_word = pos[5] ? e_word : o_word;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      win[k]     = lo_word[8*k +: 8];
      win[k + 4] = hi_word[8*k +: 8];
    end
    span = '0;
    for (int j = 0; j < WIN_BYTES; j++) begin
      addr[j] = {1'b0, pos[POS_W-1:3]} + (LEN_W+1)'(j);
      sel[j]  = 3'(pos[4:3]) + 3'(j);
      if (addr[j] < {1'b0, len_eff}) begin
        span[WIN_BITS-1-8*j -: 8] = win[sel[j]];
      end
    end
  end

  assign cnt        = (peek_count > 6'(MAX_PEEK_BITS)) ? 6'(MAX_PEEK_BITS) : peek_count;
  assign drop       = 6'(WIN_BITS) - cnt;
  assign shifted    = span << pos[2:0];
  assign aligned    = shifted >> drop;
  assign peek_value = aligned[31:0];

endmodule

// ===== sv/msb_first_bit_reader.sv =====
// ----------------------------------------------------------------------------
// msb_first_bit_reader
// MSB-first bit-stream reader over a word-banked byte store.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per transfer. A write item (operation OP_WRITE)
//   stores one byte and gives no response; a peek item returns up to 32
//   bits at the current bit position, right-aligned, then advances the
//   position (saturating at 16383) and reports bits left and overrun.
//   rsp carries one response per peek item through an output register.
//   cfg_wr_en/cfg_wr_data set the valid byte length; write it while idle.
// Sequence:
//   The transfer cycle issues the read of both store banks; the next
//   cycle uses the registered read data. A peek's response enters the
//   output register once that register is free; a write item commits
//   its read-modify-write in ST_WRITE. A new item is taken only in
//   ST_IDLE, after the last item has left ST_PEEK or ST_WRITE.
// Stall:
//   A held response does not block the next transfer; a following peek
//   waits in ST_PEEK until the output register frees up.
// Reset:
//   Clears the position, the length and the control state. The store
//   contents are undefined until written; no clearing pass is run.
// ----------------------------------------------------------------------------
module msb_first_bit_reader #(
  parameter int STORE_BYTES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [mfbr_pkg::LEN_W-1:0]    cfg_wr_data,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  mfbr_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output mfbr_pkg::rsp_t                rsp
);
  import mfbr_pkg::*;

  // Four bytes per word; even words in one bank, odd words in the other,
  // so any five-byte window is covered by one read of each bank.
  localparam int WORDS      = (STORE_BYTES + 3) / 4;
  localparam int BANK_DEPTH = (WORDS + 1) / 2;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  state_t             state;
  state_t             state_next;
  logic [LEN_W-1:0]   data_length;
  logic [POS_W-1:0]   pos;
  req_t               item;

  logic               load;
  logic               e_we;
  logic               o_we;
  logic [AW-1:0]      e_raddr;
  logic [AW-1:0]      o_raddr;
  logic [AW-1:0]      pe_row;
  logic [AW-1:0]      po_row;
  logic [8:0]         e_row_sum;
  logic [31:0]        e_rdata;
  logic [31:0]        o_rdata;
  logic [31:0]        wr_word;
  logic [31:0]        merged;
  logic               wr_in_range;

  logic [LEN_W-1:0]   len_eff;
  logic [POS_W-1:0]   total;
  logic [POS_W:0]     npos_sum;
  logic [POS_W-1:0]   npos;
  logic [31:0]        peek_value;

  // Length clipped to the store size; the valid bit count follows
  assign len_eff = (32'(data_length) > STORE_BYTES) ? LEN_W'(STORE_BYTES) : data_length;
  assign total   = {len_eff, 3'b000};

  // Bank rows holding the window at the current position
  assign e_row_sum = {1'b0, pos[13:6]} + 9'(pos[5]);
  assign pe_row    = AW'(e_row_sum);
  assign po_row    = AW'(pos[13:6]);

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.operation == OP_PEEK) ? ST_PEEK : ST_WRITE;
        end
      end
      ST_PEEK: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output decode: handshake, RAM addressing and write strobes
  // --------------------------------------------------------------------------
  always_comb begin
    req_ready = 1'b0;
    load      = 1'b0;
    e_we      = 1'b0;
    o_we      = 1'b0;
    e_raddr   = pe_row;
    o_raddr   = po_row;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        // Fetch the word a byte write lands in, for the merge
        if (req_valid && req.operation == OP_WRITE) begin
          e_raddr = AW'(req.byte_address[9:3]);
          o_raddr = AW'(req.byte_address[9:3]);
        end
      end
      ST_PEEK: begin
        // Position is unchanged here, so the re-issued read holds its data
        load = !rsp_valid || rsp_ready;
      end
      ST_WRITE: begin
        if (wr_in_range) begin
          e_we = !item.byte_address[2];
          o_we = item.byte_address[2];
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Byte merge for the read-modify-write
  // --------------------------------------------------------------------------
  assign wr_in_range = 32'(item.byte_address) < STORE_BYTES;
  assign wr_word     = item.byte_address[2] ? o_rdata : e_rdata;

  always_comb begin
    merged = wr_word;
    merged[8*item.byte_address[1:0] +: 8] = item.byte_value;
  end

  mfbr_ram #(
    .WIDTH (32),
    .DEPTH (BANK_DEPTH)
  ) u_even_bank (
    .clk   (clk),
    .we    (e_we),
    .waddr (AW'(item.byte_address[9:3])),
    .wdata (merged),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  mfbr_ram #(
    .WIDTH (32),
    .DEPTH (BANK_DEPTH)
  ) u_odd_bank (
    .clk   (clk),
    .we    (o_we),
    .waddr (AW'(item.byte_address[9:3])),
    .wdata (merged),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  // --------------------------------------------------------------------------
  // Peek extraction and position update
  // --------------------------------------------------------------------------
  mfbr_window u_window (
    .e_word     (e_rdata),
    .o_word     (o_rdata),
    .pos        (pos),
    .len_eff    (len_eff),
    .peek_count (item.peek_count),
    .peek_value (peek_value)
  );

  // Saturate the advanced position at its ceiling
  assign npos_sum = {1'b0, pos} + {1'b0, item.advance_count};
  assign npos     = (npos_sum > {1'b0, POS_MAX}) ? POS_MAX : npos_sum[POS_W-1:0];

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      data_length <= '0;
      pos         <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        data_length <= cfg_wr_data;
      end
      // Advance only as the response is taken into the output register
      if (load) begin
        pos <= npos;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold the accepted item for its ST_PEEK or ST_WRITE state
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
  end

  // Response payload; held while the receiver stalls
  always_ff @(posedge clk) begin
    if (load) begin
      rsp.peek_value <= peek_value;
      rsp.bits_left  <= (npos < total) ? (total - npos) : '0;
      rsp.overrun    <= npos > total;
    end
  end

`ifndef SYNTHESIS
  a_one_bank_write: assert property (@(posedge clk) disable iff (rst)
    !(e_we && o_we))
    else $error("both store banks written in one cycle");

  a_pos_moves_on_load: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(pos)) |-> ($past(state) == ST_PEEK && rsp_valid))
    else $error("position changed without a peek response");

  a_rsp_from_peek: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_PEEK)
    else $error("response raised outside a peek");

  a_overrun_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.overrun) |-> rsp.bits_left == '0)
    else $error("overrun reported with bits left");

  a_no_write_in_peek: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PEEK) |-> !(e_we || o_we))
    else $error("store written while a peek reads it");
`endif

endmodule
